[sv/scancode_key_state_tracker_core_macros.svh]
// ----------------------------------------------------------------------------
// Scancode key state tracker assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_KEY_STATE_TRACKER_CORE_MACROS_SVH
`define SCANCODE_KEY_STATE_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define SKTRK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication
`define SKTRK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

[sv/sktrk_pkg.sv]
// ----------------------------------------------------------------------------
// Scancode key state tracker package
// Prefix state encoding and set 1 scancode constants.
// ----------------------------------------------------------------------------
package sktrk_pkg;

	typedef enum logic [2:0] {
		PFX_IDLE = 3'b001,
		PFX_EXT  = 3'b010,
		PFX_SKIP = 3'b100
	} prefix_t;

	localparam logic [7:0] SC_EXT   = 8'hE0;
	localparam logic [7:0] SC_SKIP1 = 8'hE1;
	localparam logic [7:0] SC_SKIP2 = 8'hE2;

	localparam int BYTE_W = 8;
	localparam int KEY_W  = 7;

endpackage

[sv/sktrk_in_if.sv]
// ----------------------------------------------------------------------------
// Scancode key state tracker input channel
// Valid/ready channel carrying one byte or query item.
// ----------------------------------------------------------------------------
interface sktrk_in_if;
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic [sktrk_pkg::BYTE_W-1:0]   scan_byte;
	logic [sktrk_pkg::KEY_W-1:0]    query_key;
	logic                           query_extended;

	modport source (output valid, output op, output scan_byte, output query_key,
		output query_extended, input ready);
	modport sink (input valid, input op, input scan_byte, input query_key,
		input query_extended, output ready);
endinterface

[sv/sktrk_out_if.sv]
// ----------------------------------------------------------------------------
// Scancode key state tracker result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sktrk_out_if;
	logic                        valid;
	logic                        ready;
	logic                        key_pressed;
	logic                        event_valid;
	logic [sktrk_pkg::KEY_W-1:0] event_key;
	logic                        event_extended;
	logic                        event_pressed;

	modport source (output valid, output key_pressed, output event_valid, output event_key,
		output event_extended, output event_pressed, input ready);
	modport sink (input valid, input key_pressed, input event_valid, input event_key,
		input event_extended, input event_pressed, output ready);
endinterface

[sv/sktrk_keymap.sv]
// ----------------------------------------------------------------------------
// Scancode key state tracker key map
// One-bit-wide key map memory with per-entry valid bits cleared at reset,
// one write port and one registered read port with write-to-read bypass.
// ----------------------------------------------------------------------------
`include "scancode_key_state_tracker_core_macros.svh"

module sktrk_keymap #(
	parameter int KEY_COUNT = 96
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        we,
	input  logic [((KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1)-1:0] waddr,
	input  logic                                        wdata,
	input  logic                                        re,
	input  logic [((KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1)-1:0] raddr,
	output logic                                        rdata
);

	logic                 mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] vld_q;
	logic                 mem_rd_q;
	logic                 vld_rd_q;
	logic                 hit_q;
	logic                 hit_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			mem_rd_q   <= mem[raddr];
			vld_rd_q   <= vld_q[raddr];
			hit_q      <= we && (waddr == raddr);
			hit_data_q <= wdata;
		end
	end

	assign rdata = hit_q ? hit_data_q : (vld_rd_q & mem_rd_q);

	`SKTRK_ASSERT_NXT(a_bypass, clk, arst_n, we && re && (waddr == raddr), rdata == $past(wdata))
	`SKTRK_ASSERT_NXT(a_vld_set, clk, arst_n, we, vld_q[$past(waddr)])
	`SKTRK_ASSERT_NXT(a_unwritten, clk, arst_n, re && !vld_q[raddr] && !(we && (waddr == raddr)), !rdata)

endmodule

[sv/scancode_key_state_tracker_core.sv]
// ----------------------------------------------------------------------------
// Scancode key state tracker core
// Set 1 scancode decoder keeping normal and extended key-down maps.
// ----------------------------------------------------------------------------
// Usage:
//   scan   : valid/ready sink. op 0 feeds scan_byte, op 1 reads bit query_key
//            of the normal or extended map (query_extended).
//   result : valid/ready source, exactly one item per accepted input item.
//            Byte items report the map entry they wrote on event_*; query
//            items report the map bit on key_pressed.
//   Path:    an accepted item passes the input register, then the result
//            register.
//   Throughput: one item per cycle while result does not stall; the prefix
//            register and map write finish within the single decode stage.
//   Reset: prefix returns to idle, both maps read as all released, both
//            register stages empty.
//   Stall: while result is held, the input stage keeps one more item, then
//            scan.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "scancode_key_state_tracker_core_macros.svh"

module scancode_key_state_tracker_core #(
	parameter int KEY_COUNT = 96
) (
	input  logic         clk,
	input  logic         arst_n,
	sktrk_in_if.sink     scan,
	sktrk_out_if.source  result
);

	localparam int         AW        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam logic [7:0] KEY_LIMIT = 8'(KEY_COUNT);

	logic                         valid_s1;
	logic                         op_s1;
	logic [sktrk_pkg::BYTE_W-1:0] byte_s1;
	logic                         qext_s1;
	logic                         qok_s1;

	logic                         out_valid_q;
	logic                         key_pressed_q;
	logic                         event_valid_q;
	logic [sktrk_pkg::KEY_W-1:0]  event_key_q;
	logic                         event_extended_q;
	logic                         event_pressed_q;

	sktrk_pkg::prefix_t prefix_q;
	sktrk_pkg::prefix_t prefix_next;

	logic          adv;
	logic          in_fire;
	logic          qok_in;
	logic          key_ok;
	logic          make;
	logic          dec_we_n;
	logic          dec_we_e;
	logic          we_n;
	logic          we_e;
	logic          ev_valid;
	logic          rd_n;
	logic          rd_e;
	logic [AW-1:0] key_idx;

	assign adv        = valid_s1 && (!out_valid_q || result.ready);
	assign scan.ready = !valid_s1 || adv;
	assign in_fire    = scan.valid && scan.ready;
	assign qok_in     = {1'b0, scan.query_key} < KEY_LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= scan.op;
			byte_s1 <= scan.scan_byte;
			qext_s1 <= scan.query_extended;
			qok_s1  <= qok_in;
		end
	end

	// decode
	assign key_ok  = {1'b0, byte_s1[6:0]} < KEY_LIMIT;
	assign make    = !byte_s1[7];
	assign key_idx = byte_s1[AW-1:0];

	always_comb begin
		prefix_next = sktrk_pkg::PFX_IDLE;
		dec_we_n    = 1'b0;
		dec_we_e    = 1'b0;
		case (prefix_q)
			sktrk_pkg::PFX_EXT: begin
				dec_we_e = key_ok;
			end
			sktrk_pkg::PFX_IDLE: begin
				if (byte_s1 == sktrk_pkg::SC_EXT) begin
					prefix_next = sktrk_pkg::PFX_EXT;
				end else if (byte_s1 inside {sktrk_pkg::SC_SKIP1, sktrk_pkg::SC_SKIP2}) begin
					prefix_next = sktrk_pkg::PFX_SKIP;
				end else begin
					dec_we_n = key_ok;
				end
			end
			default: begin
				prefix_next = sktrk_pkg::PFX_IDLE;
			end
		endcase
	end

	assign we_n     = adv && !op_s1 && dec_we_n;
	assign we_e     = adv && !op_s1 && dec_we_e;
	assign ev_valid = !op_s1 && (dec_we_n || dec_we_e);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= sktrk_pkg::PFX_IDLE;
		end else if (adv && !op_s1) begin
			prefix_q <= prefix_next;
		end
	end

	sktrk_keymap #(
		.KEY_COUNT (KEY_COUNT)
	) u_map_n (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we_n),
		.waddr  (key_idx),
		.wdata  (make),
		.re     (in_fire && qok_in),
		.raddr  (scan.query_key[AW-1:0]),
		.rdata  (rd_n)
	);

	sktrk_keymap #(
		.KEY_COUNT (KEY_COUNT)
	) u_map_e (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we_e),
		.waddr  (key_idx),
		.wdata  (make),
		.re     (in_fire && qok_in),
		.raddr  (scan.query_key[AW-1:0]),
		.rdata  (rd_e)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_pressed_q    <= op_s1 && qok_s1 && (qext_s1 ? rd_e : rd_n);
			event_valid_q    <= ev_valid;
			event_key_q      <= ev_valid ? byte_s1[6:0] : '0;
			event_extended_q <= ev_valid && dec_we_e;
			event_pressed_q  <= ev_valid && make;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.key_pressed    = key_pressed_q;
	assign result.event_valid    = event_valid_q;
	assign result.event_key      = event_key_q;
	assign result.event_extended = event_extended_q;
	assign result.event_pressed  = event_pressed_q;

	`SKTRK_ASSERT_IMP(a_one_map, clk, arst_n, we_n || we_e, !(we_n && we_e))
	`SKTRK_ASSERT_NXT(a_ext_arm, clk, arst_n, adv && !op_s1 && (prefix_q == sktrk_pkg::PFX_IDLE) && (byte_s1 == sktrk_pkg::SC_EXT), prefix_q == sktrk_pkg::PFX_EXT)
	`SKTRK_ASSERT_NXT(a_pfx_clear, clk, arst_n, adv && !op_s1 && (prefix_q != sktrk_pkg::PFX_IDLE), prefix_q == sktrk_pkg::PFX_IDLE)
	`SKTRK_ASSERT_IMP(a_excl, clk, arst_n, result.valid && result.event_valid, !result.key_pressed)
	`SKTRK_ASSERT_NXT(a_s1_hold, clk, arst_n, valid_s1 && !adv, valid_s1)

endmodule

[bench/scancode_key_state_tracker_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scancode key state tracker core testbench
// Feeds set 1 byte and query items through the scan channel and checks every
// result item against a bit-accurate model of the prefix state and both key
// maps. Directed prefix and range cases come first, then random make/break,
// extended and skip sequences with noise. Both channels idle at random; one
// phase holds off results until the input stalls, another drains the block.
// ----------------------------------------------------------------------------
module scancode_key_state_tracker_core_tb;

	localparam int  KEY_COUNT   = 96;
	localparam bit  OP_BYTE     = 1'b0;
	localparam bit  OP_QUERY    = 1'b1;
	localparam int  CYCLE_LIMIT = 200000;
	localparam int  ITEM_TARGET = 450;

	typedef struct packed {
		logic       key_pressed;
		logic       event_valid;
		logic [6:0] event_key;
		logic       event_extended;
		logic       event_pressed;
	} key_report_t;

	class key_map_scoreboard;
		sktrk_pkg::prefix_t cur_prefix = sktrk_pkg::PFX_IDLE;
		bit [127:0]    normal_map = '0;
		bit [127:0]    extended_map = '0;
		key_report_t   expected_reports[$];
		int            errors = 0;

		function void apply_item(bit op, bit [7:0] scan_byte, bit [6:0] qkey, bit qext);
			key_report_t rep;
			bit [6:0]    idx;
			bit          make;
			rep = '0;
			idx = scan_byte[6:0];
			make = ~scan_byte[7];
			if (op == OP_QUERY) begin
				if (qkey < KEY_COUNT)
					rep.key_pressed = qext ? extended_map[qkey] : normal_map[qkey];
			end else begin
				case (cur_prefix)
					sktrk_pkg::PFX_EXT: begin
						if (idx < KEY_COUNT) begin
							extended_map[idx] = make;
							rep.event_valid = 1'b1;
							rep.event_key = idx;
							rep.event_extended = 1'b1;
							rep.event_pressed = make;
						end
						cur_prefix = sktrk_pkg::PFX_IDLE;
					end
					sktrk_pkg::PFX_SKIP: begin
						cur_prefix = sktrk_pkg::PFX_IDLE;
					end
					default: begin
						if (scan_byte == sktrk_pkg::SC_EXT)
							cur_prefix = sktrk_pkg::PFX_EXT;
						else if (scan_byte == sktrk_pkg::SC_SKIP1 ||
							scan_byte == sktrk_pkg::SC_SKIP2)
							cur_prefix = sktrk_pkg::PFX_SKIP;
						else if (idx < KEY_COUNT) begin
							normal_map[idx] = make;
							rep.event_valid = 1'b1;
							rep.event_key = idx;
							rep.event_pressed = make;
						end
					end
				endcase
			end
			expected_reports.push_back(rep);
		endfunction

		function void report_field(string name, int exp_val, int act_val);
			if (exp_val != act_val) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_report(key_report_t act);
			key_report_t exp_rep;
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected result item, expected none, actual %h", $time, act);
				errors++;
			end else begin
				exp_rep = expected_reports.pop_front();
				report_field("key_pressed", int'(exp_rep.key_pressed), int'(act.key_pressed));
				report_field("event_valid", int'(exp_rep.event_valid), int'(act.event_valid));
				report_field("event_key", int'(exp_rep.event_key), int'(act.event_key));
				report_field("event_extended", int'(exp_rep.event_extended),
					int'(act.event_extended));
				report_field("event_pressed", int'(exp_rep.event_pressed),
					int'(act.event_pressed));
			end
		endfunction

		function int pending_count();
			return expected_reports.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sktrk_in_if  scan_ch();
	sktrk_out_if res_ch();

	scancode_key_state_tracker_core #(
		.KEY_COUNT(KEY_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.scan(scan_ch),
		.result(res_ch)
	);

	key_map_scoreboard board = new();

	int cycle_count = 0;
	int items_sent = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit rx_hold_req = 1'b0;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			board.check_report({res_ch.key_pressed, res_ch.event_valid, res_ch.event_key,
				res_ch.event_extended, res_ch.event_pressed});
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int idle_cycles();
		if (tx_steady)
			return 0;
		if ($urandom_range(0, 99) < 55)
			return 0;
		return pick_gap();
	endfunction

	function automatic bit [6:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 7'($urandom_range(0, 15));
		if (r < 90)
			return 7'($urandom_range(0, KEY_COUNT - 1));
		return 7'($urandom_range(KEY_COUNT, 127));
	endfunction

	// result side: random stalls, long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall_left = 250;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				if (!rx_steady && $urandom_range(0, 99) < 25)
					stall_left = pick_gap();
			end
		end
	end

	task automatic push_item(bit op, bit [7:0] scan_byte, bit [6:0] qkey, bit qext);
		int gap;
		scan_ch.op <= op;
		scan_ch.scan_byte <= scan_byte;
		scan_ch.query_key <= qkey;
		scan_ch.query_extended <= qext;
		scan_ch.valid <= 1'b1;
		do @(posedge clk); while (scan_ch.ready !== 1'b1);
		board.apply_item(op, scan_byte, qkey, qext);
		items_sent++;
		gap = idle_cycles();
		if (gap > 0) begin
			scan_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic feed_byte(bit [7:0] scan_byte);
		push_item(OP_BYTE, scan_byte, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
	endtask

	task automatic query_map(bit [6:0] qkey, bit qext);
		push_item(OP_QUERY, 8'($urandom_range(0, 255)), qkey, qext);
	endtask

	task automatic random_sequence();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			feed_byte({1'($urandom_range(0, 1)), pick_key()});
		else if (r < 60) begin
			feed_byte(sktrk_pkg::SC_EXT);
			feed_byte({1'($urandom_range(0, 1)), pick_key()});
		end else if (r < 68) begin
			feed_byte($urandom_range(0, 1) ? sktrk_pkg::SC_SKIP1 : sktrk_pkg::SC_SKIP2);
			feed_byte(8'($urandom_range(0, 255)));
		end else if (r < 88)
			query_map(pick_key(), 1'($urandom_range(0, 1)));
		else
			feed_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		scan_ch.valid <= 1'b0;
		scan_ch.op <= OP_BYTE;
		scan_ch.scan_byte <= '0;
		scan_ch.query_key <= '0;
		scan_ch.query_extended <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset state, range limits, prefix handling
		query_map(7'd0, 1'b0);
		query_map(7'd95, 1'b1);
		query_map(7'd127, 1'b0);
		feed_byte(8'h00);
		feed_byte(8'h5F);
		feed_byte(8'h60);
		feed_byte(8'hFF);
		query_map(7'd0, 1'b0);
		query_map(7'd96, 1'b0);
		feed_byte(sktrk_pkg::SC_EXT);
		feed_byte(8'h1D);
		query_map(7'h1D, 1'b1);
		feed_byte(sktrk_pkg::SC_EXT);
		feed_byte(sktrk_pkg::SC_EXT);
		feed_byte(sktrk_pkg::SC_EXT);
		feed_byte(8'h5F);
		query_map(7'd95, 1'b1);
		feed_byte(sktrk_pkg::SC_SKIP1);
		feed_byte(sktrk_pkg::SC_EXT);
		feed_byte(8'h10);
		feed_byte(sktrk_pkg::SC_SKIP2);
		feed_byte(8'h90);
		feed_byte(8'h80);
		feed_byte(sktrk_pkg::SC_EXT);
		feed_byte(8'hDF);

		while (items_sent < 180)
			random_sequence();

		// hold off results so the input stage fills and stalls
		tx_steady = 1'b1;
		rx_hold_req = 1'b1;
		while (items_sent < 215)
			random_sequence();
		tx_steady = 1'b0;
		scan_ch.valid <= 1'b0;
		while (board.pending_count() != 0)
			@(posedge clk);

		tx_steady = 1'b1;
		rx_steady = 1'b1;
		while (items_sent < 300)
			random_sequence();
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		while (items_sent < ITEM_TARGET)
			random_sequence();
		scan_ch.valid <= 1'b0;

		while (board.pending_count() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[filelist.f]
+incdir+sv
sv/sktrk_pkg.sv
sv/sktrk_in_if.sv
sv/sktrk_out_if.sv
sv/sktrk_keymap.sv
sv/scancode_key_state_tracker_core.sv
bench/scancode_key_state_tracker_core_tb.sv
